// ===== rtl/lags_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lags_pkg
// Shared types, widths, codes and the B3/S23 row update for the life grid.
// ----------------------------------------------------------------------------
package lags_pkg;

  // Default grid geometry
  localparam int GRID_ROWS_DEF = 64;
  localparam int GRID_COLS_DEF = 64;

  // Payload widths
  localparam int ROW_W   = 64;
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COLS = 1'd1;
  localparam logic [CFG_DATA_W-1:0] ACTIVE_ROWS_RST = 7'd64;
  localparam logic [CFG_DATA_W-1:0] ACTIVE_COLS_RST = 7'd64;

  // Command codes (code 3 is a no-op)
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_STEP,
    ST_DONE
  } lags_state_t;

  // One generation of one row from its three-row window; outside cells dead
  function automatic logic [ROW_W-1:0] life_row(input logic [ROW_W-1:0] above,
                                                input logic [ROW_W-1:0] here,
                                                input logic [ROW_W-1:0] below);
    logic [ROW_W+1:0] pa;
    logic [ROW_W+1:0] ph;
    logic [ROW_W+1:0] pb;
    logic [3:0]       n;
    logic [ROW_W-1:0] res;
    pa = {1'b0, above, 1'b0};
    ph = {1'b0, here, 1'b0};
    pb = {1'b0, below, 1'b0};
    for (int j = 0; j < ROW_W; j++) begin
      n = 4'(pa[j]) + 4'(pa[j+1]) + 4'(pa[j+2])
        + 4'(ph[j]) + 4'(ph[j+2])
        + 4'(pb[j]) + 4'(pb[j+1]) + 4'(pb[j+2]);
      res[j] = (n == 4'd3) || (here[j] && (n == 4'd2));
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lags_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lags_req_if
// Command channel: valid/ready handshake with command, row index and cells.
// ----------------------------------------------------------------------------
interface lags_req_if import lags_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [INDEX_W-1:0] row_index;
  logic [ROW_W-1:0]   row_cells;

  modport source (output valid, command, row_index, row_cells, input ready);
  modport sink   (input valid, command, row_index, row_cells, output ready);
endinterface
`default_nettype wire

// ===== rtl/lags_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lags_rsp_if
// Response channel: valid/ready handshake with read cells and status.
// ----------------------------------------------------------------------------
interface lags_rsp_if import lags_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] read_cells;
  logic             status;

  modport source (output valid, read_cells, status, input ready);
  modport sink   (input valid, read_cells, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/lags_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lags_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lags_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/life_automaton_grid_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// life_automaton_grid_step
// Grid of one-bit cells under the B3/S23 rule, one RAM word per row, with
// row write, row read and whole-grid generation step. Two row buffers swap
// roles after each step.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+--------------------------------------
//  request   | in  | valid/ready        | command, row_index, row_cells
//  response  | out | valid/ready        | read_cells, status
//  cfg       | in  | cfg_write (no wait)| cfg_index, cfg_data
//
//  Write, no-op and out-of-range commands pass from EXEC straight to DONE;
//  a read passes through RDWAIT. A step makes one RAM read per row through a
//  three-row window, each new row written in the cycle after the read of its
//  lower neighbor.
//  After reset a clearing pass zeroes every row of the current buffer;
//  no transaction is taken meanwhile. One transaction is in work at a time;
//  a finished response waits in the output register while the next is taken.
// ----------------------------------------------------------------------------
module life_automaton_grid_step import lags_pkg::*; #(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  lags_req_if.sink                   request,
  lags_rsp_if.source                 response
);

  localparam int AW = $clog2(GRID_ROWS);
  localparam int PW = AW + 1;
  localparam int CW = (PW > CFG_DATA_W) ? PW : CFG_DATA_W;

  lags_state_t state;
  lags_state_t state_next;

  // Configuration
  logic [CFG_DATA_W-1:0] active_rows;
  logic [CFG_DATA_W-1:0] active_cols;
  logic [CFG_DATA_W-1:0] cols_used;
  logic [CW-1:0]         rows_used;
  logic [ROW_W-1:0]      col_mask;

  // Latched transaction
  logic [CMD_W-1:0]   cmd_q;
  logic [INDEX_W-1:0] index_q;
  logic [ROW_W-1:0]   cells_q;
  logic               row_ok;

  // Step sequencing
  logic [PW-1:0]    cnt;
  logic             rd_vld;
  logic [PW-1:0]    rd_row;
  logic             step_done;
  logic             sel;
  logic [ROW_W-1:0] win_above;
  logic [ROW_W-1:0] win_here;
  logic [ROW_W-1:0] in_row;
  logic [ROW_W-1:0] step_row;

  // Result and output register
  logic [ROW_W-1:0] res_cells;
  logic             res_status;
  logic             out_valid;
  logic [ROW_W-1:0] out_cells;
  logic             out_status;
  logic             slot_free;

  // RAM ports
  logic             mem_we;
  logic             mem_wsel;
  logic [AW-1:0]    waddr;
  logic [ROW_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [ROW_W-1:0] q0;
  logic [ROW_W-1:0] q1;
  logic [ROW_W-1:0] mem_q;

  // Row buffers
  lags_ram #(.WIDTH(ROW_W), .DEPTH(GRID_ROWS)) u_buf0 (
    .clk   (clk),
    .we    (mem_we && !mem_wsel),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (q0)
  );

  lags_ram #(.WIDTH(ROW_W), .DEPTH(GRID_ROWS)) u_buf1 (
    .clk   (clk),
    .we    (mem_we && mem_wsel),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (q1)
  );

  assign mem_q = sel ? q1 : q0;

  // Active geometry, saturated at the grid size
  always_comb begin
    cols_used = (active_cols > CFG_DATA_W'(GRID_COLS)) ? CFG_DATA_W'(GRID_COLS)
                                                       : active_cols;
    rows_used = (CW'(active_rows) > CW'(GRID_ROWS)) ? CW'(GRID_ROWS)
                                                    : CW'(active_rows);
    for (int j = 0; j < ROW_W; j++) begin
      col_mask[j] = CFG_DATA_W'(j) < cols_used;
    end
  end

  assign row_ok = CW'(index_q) < rows_used;

  // Step window datapath
  assign in_row    = (CW'(rd_row) < rows_used) ? (mem_q & col_mask) : '0;
  assign step_row  = (CW'(rd_row - PW'(1)) < rows_used)
                   ? (life_row(win_above, win_here, in_row) & col_mask) : '0;
  assign step_done = rd_vld && (rd_row == PW'(GRID_ROWS));

  assign slot_free = !out_valid || response.ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (cnt == PW'(GRID_ROWS - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (request.valid) state_next = ST_EXEC;
      ST_EXEC: begin
        if (cmd_q == CMD_READ && row_ok) begin
          state_next = ST_RDWAIT;
        end else if (cmd_q == CMD_STEP) begin
          state_next = ST_STEP;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_RDWAIT: state_next = ST_DONE;
      ST_STEP:   if (step_done) state_next = ST_DONE;
      ST_DONE:   if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // RAM controls
  always_comb begin
    mem_we   = 1'b0;
    mem_wsel = sel;
    waddr    = cnt[AW-1:0];
    wdata    = '0;
    raddr    = cnt[AW-1:0];
    unique case (state)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_wsel = 1'b0;
      end
      ST_EXEC: begin
        raddr = AW'(index_q);
        if (cmd_q == CMD_WRITE && row_ok) begin
          mem_we = 1'b1;
          waddr  = AW'(index_q);
          wdata  = cells_q & col_mask;
        end
      end
      ST_STEP: begin
        mem_wsel = ~sel;
        waddr    = AW'(rd_row - PW'(1));
        wdata    = step_row;
        mem_we   = rd_vld && (rd_row != '0);
      end
      default: ;
    endcase
  end

  assign request.ready = (state == ST_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      cnt         <= '0;
      rd_vld      <= 1'b0;
      rd_row      <= '0;
      sel         <= 1'b0;
      out_valid   <= 1'b0;
      active_rows <= ACTIVE_ROWS_RST;
      active_cols <= ACTIVE_COLS_RST;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          CFG_ACTIVE_ROWS: active_rows <= cfg_data;
          CFG_ACTIVE_COLS: active_cols <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        ST_CLEAR: cnt <= cnt + PW'(1);
        ST_EXEC: begin
          cnt    <= '0;
          rd_vld <= 1'b0;
        end
        ST_STEP: begin
          // issue reads for rows 0..GRID_ROWS-1 plus one flush slot
          if (cnt <= PW'(GRID_ROWS)) begin
            rd_vld <= 1'b1;
            rd_row <= cnt;
            cnt    <= cnt + PW'(1);
          end else begin
            rd_vld <= 1'b0;
          end
          if (step_done) sel <= ~sel;
        end
        default: ;
      endcase

      // Output register
      if (state == ST_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && request.valid) begin
      cmd_q   <= request.command;
      index_q <= request.row_index;
      cells_q <= request.row_cells;
    end

    case (state)
      ST_EXEC: begin
        win_above  <= '0;
        win_here   <= '0;
        res_cells  <= '0;
        res_status <= ((cmd_q == CMD_WRITE) || (cmd_q == CMD_READ)) && !row_ok;
      end
      ST_RDWAIT: res_cells <= mem_q & col_mask;
      ST_STEP: begin
        if (rd_vld) begin
          win_above <= win_here;
          win_here  <= in_row;
        end
      end
      default: ;
    endcase

    if (state == ST_DONE && slot_free) begin
      out_cells  <= res_cells;
      out_status <= res_status;
    end
  end

  assign response.valid      = out_valid;
  assign response.read_cells = out_cells;
  assign response.status     = out_status;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the life grid. Row writes, row reads and
// generation steps are sent under several row and column settings, the
// extremes among them. Every command is mirrored in a local copy of the
// grid, and each response is compared against it. Both channels idle at
// random, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import lags_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;  // unused code, no operation
  localparam int LIMIT_CYCLES = 500000;
  localparam int IDLE_PCT     = 34;
  localparam int HOLD_AT      = 120;            // transactions before the hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_FROM   = 300;            // no idling from here ...
  localparam int QUIET_TO     = 420;            // ... up to here
  localparam int DRAIN_CYCLES = GRID_ROWS_DEF + 8;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [INDEX_W-1:0] row_index;
    logic [ROW_W-1:0]   row_cells;
  } grid_cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0] read_cells;
    logic             status;
  } row_reply_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lags_req_if req_ch ();
  lags_rsp_if rsp_ch ();

  life_automaton_grid_step uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .request  (req_ch),
    .response (rsp_ch)
  );

  // Shadow grid and register copies
  logic [ROW_W-1:0]      life_grid [GRID_ROWS_DEF];
  logic [CFG_DATA_W-1:0] rows_reg;
  logic [CFG_DATA_W-1:0] cols_reg;

  grid_cmd_t  cmd_backlog [$];
  row_reply_t due_replies [$];
  grid_cmd_t  offered;

  int  accepted_cnt;
  int  mismatch_cnt;
  int  hold_left;
  bit  hold_done;
  int  cycle_cnt;
  logic quiet;

  assign quiet = (accepted_cnt >= QUIET_FROM) && (accepted_cnt < QUIET_TO);

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int rows_in_use();
    return (rows_reg > GRID_ROWS_DEF) ? GRID_ROWS_DEF : int'(rows_reg);
  endfunction

  function automatic logic [ROW_W-1:0] column_mask();
    int c;
    c = (cols_reg > GRID_COLS_DEF) ? GRID_COLS_DEF : int'(cols_reg);
    if (c >= ROW_W) return '1;
    return (64'd1 << c) - 64'd1;
  endfunction

  // B3/S23 over the rows in use; everything outside counts as dead
  function automatic void next_generation();
    logic [ROW_W-1:0] fresh [GRID_ROWS_DEF];
    logic [ROW_W-1:0] win [3];
    logic [ROW_W-1:0] mask;
    int nr;
    int live;
    nr = rows_in_use();
    mask = column_mask();
    for (int r = 0; r < GRID_ROWS_DEF; r++) begin
      fresh[r] = '0;
      if (r < nr) begin
        win[0] = (r > 0) ? (life_grid[r-1] & mask) : '0;
        win[1] = life_grid[r] & mask;
        win[2] = (r + 1 < nr) ? (life_grid[r+1] & mask) : '0;
        for (int j = 0; j < ROW_W; j++) begin
          live = 0;
          for (int dr = 0; dr < 3; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              if (!(dr == 1 && dc == 0) && (j + dc >= 0) && (j + dc < ROW_W))
                live += int'(win[dr][j+dc]);
            end
          end
          fresh[r][j] = (live == 3) || (win[1][j] && live == 2);
        end
        fresh[r] &= mask;
      end
    end
    life_grid = fresh;
  endfunction

  // Apply one accepted command to the shadow grid, queue its response
  function automatic void apply_command(input grid_cmd_t c);
    row_reply_t r;
    r = '0;
    case (c.command)
      CMD_WRITE, CMD_READ: begin
        if (int'(c.row_index) >= rows_in_use()) begin
          r.status = 1'b1;
        end else if (c.command == CMD_WRITE) begin
          life_grid[c.row_index] = c.row_cells & column_mask();
        end else begin
          r.read_cells = life_grid[c.row_index] & column_mask();
        end
      end
      CMD_STEP: next_generation();
      default: ;
    endcase
    due_replies.push_back(r);
  endfunction

  function automatic logic [ROW_W-1:0] random_cells();
    logic [ROW_W-1:0] w;
    case ($urandom_range(0, 4))
      0: w = {$urandom, $urandom};
      1: w = {$urandom, $urandom} & {$urandom, $urandom};
      2: w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      3: w = 64'd7 << $urandom_range(0, 61);
      default: w = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return w;
  endfunction

  // Mostly in-range writes, reads and steps; a little noise
  function automatic grid_cmd_t random_command();
    grid_cmd_t it;
    int nr;
    int pick;
    nr = rows_in_use();
    pick = $urandom_range(0, 99);
    it.row_cells = random_cells();
    if (pick < 45)      it.command = CMD_WRITE;
    else if (pick < 80) it.command = CMD_READ;
    else if (pick < 95) it.command = CMD_STEP;
    else                it.command = CMD_NOP;
    if (nr == 0 || $urandom_range(0, 9) == 0)
      it.row_index = INDEX_W'($urandom_range(0, 63));
    else
      it.row_index = INDEX_W'($urandom_range(0, nr - 1));
    return it;
  endfunction

  task automatic queue_item(input logic [CMD_W-1:0] cmd, input int idx,
                            input logic [ROW_W-1:0] cells);
    grid_cmd_t it;
    it.command = cmd;
    it.row_index = INDEX_W'(idx);
    it.row_cells = cells;
    cmd_backlog.push_back(it);
  endtask

  // Both registers, one per clock; called right after a rising edge
  task automatic program_grid(input logic [CFG_DATA_W-1:0] rows,
                              input logic [CFG_DATA_W-1:0] cols);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ACTIVE_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_index <= CFG_ACTIVE_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_write <= 1'b0;
    rows_reg = rows;
    cols_reg = cols;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (cmd_backlog.size() != 0 || req_ch.valid || due_replies.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    logic [CFG_DATA_W-1:0] plan_rows [9];
    logic [CFG_DATA_W-1:0] plan_cols [9];
    int plan_len [9];
    plan_rows = '{7'd64, 7'd20, 7'd127, 7'd1, 7'd0, 7'd64, 7'd3, 7'd0, 7'd64};
    plan_cols = '{7'd64, 7'd33, 7'd127, 7'd64, 7'd0, 7'd1, 7'd3, 7'd0, 7'd64};
    plan_len  = '{150, 75, 80, 30, 20, 30, 40, 100, 100};
    // random geometry for one phase
    plan_rows[7] = CFG_DATA_W'($urandom_range(1, 64));
    plan_cols[7] = CFG_DATA_W'($urandom_range(1, 64));

    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_WRITE;
    req_ch.row_index = '0;
    req_ch.row_cells = '0;
    rsp_ch.ready = 1'b0;
    rows_reg = ACTIVE_ROWS_RST;
    cols_reg = ACTIVE_COLS_RST;
    for (int r = 0; r < GRID_ROWS_DEF; r++) life_grid[r] = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // let the post-reset clearing pass finish before touching registers
    repeat (DRAIN_CYCLES) @(posedge clk);

    for (int p = 0; p < 9; p++) begin
      program_grid(plan_rows[p], plan_cols[p]);
      if (p == 0) begin
        // border rows and corner columns, then one step over them
        queue_item(CMD_WRITE, 0, '1);
        queue_item(CMD_WRITE, 63, '1);
        queue_item(CMD_WRITE, 1, 64'h8000_0000_0000_0001);
        queue_item(CMD_READ, 0, '0);
        queue_item(CMD_READ, 63, '0);
        queue_item(CMD_READ, 1, '1);
        queue_item(CMD_STEP, 0, '0);
        queue_item(CMD_READ, 0, '0);
        queue_item(CMD_READ, 1, '0);
        queue_item(CMD_READ, 63, '0);
        queue_item(CMD_NOP, 63, '1);
        queue_item(CMD_WRITE, 0, '0);
        queue_item(CMD_WRITE, 63, '0);
        queue_item(CMD_WRITE, 1, '0);
        // glider against column 0
        queue_item(CMD_WRITE, 10, 64'h2);
        queue_item(CMD_WRITE, 11, 64'h4);
        queue_item(CMD_WRITE, 12, 64'h7);
        queue_item(CMD_STEP, 5, '1);
        queue_item(CMD_STEP, 0, '0);
        queue_item(CMD_READ, 11, '0);
        queue_item(CMD_READ, 12, '0);
        queue_item(CMD_READ, 13, '0);
      end else if (p == 1) begin
        // out-of-range rows and masked columns
        queue_item(CMD_WRITE, 40, '1);
        queue_item(CMD_READ, 63, '0);
        queue_item(CMD_WRITE, 19, '1);
        queue_item(CMD_READ, 19, '0);
      end
      for (int k = 0; k < plan_len[p]; k++) cmd_backlog.push_back(random_command());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && due_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Request driver: holds an offer until taken, idles at random between offers
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        apply_command(offered);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (cmd_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          offered = cmd_backlog.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.command   <= offered.command;
          req_ch.row_index <= offered.row_index;
          req_ch.row_cells <= offered.row_cells;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long response hold-off, once, so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Response monitor and checker
  always @(posedge clk) begin
    row_reply_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_replies.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected response: read_cells %h status %b",
                     rsp_ch.read_cells, rsp_ch.status);
        end else begin
          want = due_replies.pop_front();
          if (rsp_ch.read_cells !== want.read_cells || rsp_ch.status !== want.status) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: read_cells exp %h got %h, status exp %b got %b",
                       want.read_cells, rsp_ch.read_cells, want.status, rsp_ch.status);
          end
        end
      end
      rsp_ch.ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    accepted_cnt = 0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
  end

endmodule

// ===== life_automaton_grid_step.f =====
rtl/lags_pkg.sv
rtl/lags_req_if.sv
rtl/lags_rsp_if.sv
rtl/lags_ram.sv
rtl/life_automaton_grid_step.sv
verif/tb_top.sv
